// ===== rtl/gcr_pkg.sv =====
// Shared types and constants for the glyph character rounding unit.
// Used by gcr_scanline and glyph_character_rounding_unit; depends on nothing.
package gcr_pkg;

	// Glyph geometry: source glyph and the cell each source pixel becomes.
	localparam int GlyphRows = 10;
	localparam int GlyphCols = 6;
	localparam int CellW     = 4;
	localparam int CellH     = 3;
	localparam int Scanlines = GlyphRows * CellH;
	localparam int LineW     = GlyphCols * CellW;
	localparam int GlyphW    = GlyphRows * GlyphCols;
	localparam int IndexW    = $clog2(Scanlines);

	// Row window: one clear row above and below the glyph.
	localparam int WinRows = GlyphRows + 2;

	typedef logic [GlyphCols-1:0] row_t;
	typedef logic [LineW-1:0]     line_t;
	typedef logic [IndexW-1:0]    index_t;
	typedef logic [1:0]           sub_t;

	// Scanline position within a cell.
	localparam sub_t SubTop = 2'd0;
	localparam sub_t SubMid = 2'd1;
	localparam sub_t SubBot = 2'd2;

	localparam index_t LastLine = IndexW'(Scanlines - 1);

endpackage

// ===== rtl/gcr_scanline.sv =====
// Combinational scanline builder: turns a window of three glyph rows into one
// 24-pixel scanline with optional corner rounding. Depends on gcr_pkg.
module gcr_scanline
	import gcr_pkg::*;
(
	input  row_t  prev_row,
	input  row_t  cur_row,
	input  row_t  next_row,
	input  sub_t  sub,
	input  logic  round_en,
	output line_t pixels
);

	// Rows padded with a clear pixel at each side, so edge neighbours read as clear.
	logic [GlyphCols+1:0] prev_ext;
	logic [GlyphCols+1:0] cur_ext;
	logic [GlyphCols+1:0] next_ext;

	assign prev_ext = {1'b0, prev_row, 1'b0};
	assign cur_ext  = {1'b0, cur_row, 1'b0};
	assign next_ext = {1'b0, next_row, 1'b0};

	// Four-pixel pattern of one cell on the current scanline; leftmost pixel in bit 3.
	function automatic logic [CellW-1:0] cell_pattern(
		input logic centre,
		input logic n, input logic s, input logic w, input logic e,
		input logic nw, input logic ne, input logic se, input logic sw,
		input sub_t sl, input logic rnd
	);
		logic [CellW-1:0] fill;
		fill = '0;
		if (centre) begin
			fill = '1;
		end else if (rnd) begin
			unique case (sl)
				SubTop: begin
					if (n && w && !nw) fill = fill | 4'b1110;
					if (n && e && !ne) fill = fill | 4'b0111;
				end
				SubMid: begin
					if ((n && w && !nw) || (s && w && !sw)) fill = fill | 4'b1000;
					if ((n && e && !ne) || (s && e && !se)) fill = fill | 4'b0001;
				end
				SubBot: begin
					if (s && e && !se) fill = fill | 4'b0111;
					if (s && w && !sw) fill = fill | 4'b1110;
				end
				default: begin
					fill = '0;
				end
			endcase
		end
		return fill;
	endfunction

	// One cell per source column; column c sits at bit GlyphCols-c of the padded rows.
	for (genvar c = 0; c < GlyphCols; c++) begin : g_col
		localparam int P = GlyphCols - c;
		assign pixels[CellW*(GlyphCols-1-c) +: CellW] = cell_pattern(
			cur_ext[P],
			prev_ext[P], next_ext[P], cur_ext[P+1], cur_ext[P-1],
			prev_ext[P+1], prev_ext[P-1], next_ext[P-1], next_ext[P+1],
			sub, round_en);
	end

endmodule

// ===== rtl/glyph_character_rounding_unit.sv =====
// Top level of the glyph character rounding unit: input glyph register with
// row window, scanline sequencing and output word register. Depends on gcr_pkg, gcr_scanline.
//
//  Channel  Handshake                Payload
//  in       in_valid / in_stall      glyph_rows[59:0], is_alphanumeric
//  out      out_valid / out_stall    scanline_pixels[23:0], scanline_index[4:0], last_scanline
//  cfg      cfg_valid / cfg_ready    rounding_disable
//
// Each glyph gives 30 output words through the single output register, one per
// cycle unless the output stalls. The next glyph is taken in the cycle its
// predecessor's last scanline is issued, so glyphs follow one another with no
// gap. A stall on the output holds the word and freezes the sequence. Reset
// clears the sequencer, the output valid flag and the rounding_disable register;
// the window and payload registers are not reset.
module glyph_character_rounding_unit
	import gcr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [GlyphW-1:0]   glyph_rows,
	input  logic                is_alphanumeric,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [LineW-1:0]    scanline_pixels,
	output logic [IndexW-1:0]   scanline_index,
	output logic                last_scanline,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                rounding_disable
);

	logic   rounding_disable_q;
	logic   busy_s1;
	logic   round_s1;
	row_t   win_s1 [WinRows];
	sub_t   sub_s1;
	index_t line_s1;

	logic   out_valid_q;
	line_t  pixels_q;
	index_t index_q;
	logic   last_q;

	logic   load_out;
	logic   last_line;
	logic   in_acc;
	logic   row_done;
	line_t  line_pixels;

	// Configuration register; always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounding_disable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			rounding_disable_q <= rounding_disable;
		end
	end

	// Handshake control: a word moves to the output register when it is empty or draining.
	assign load_out  = busy_s1 && (!out_valid_q || !out_stall);
	assign last_line = (line_s1 == LastLine);
	assign row_done  = (sub_s1 == SubBot);
	assign in_stall  = busy_s1 && !(load_out && last_line);
	assign in_acc    = in_valid && !in_stall;

	// Sequencer state: busy flag, sub-scanline and scanline counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			sub_s1  <= SubTop;
			line_s1 <= '0;
		end else if (in_acc) begin
			busy_s1 <= 1'b1;
			sub_s1  <= SubTop;
			line_s1 <= '0;
		end else if (load_out) begin
			if (last_line) begin
				busy_s1 <= 1'b0;
			end
			sub_s1  <= row_done ? SubTop : sub_s1 + 2'd1;
			line_s1 <= line_s1 + IndexW'(1);
		end
	end

	// Row window: loaded with the glyph between two clear rows, shifted up one row
	// after the bottom scanline of each cell row.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			round_s1   <= is_alphanumeric && !rounding_disable_q;
			win_s1[0]  <= '0;
			win_s1[WinRows-1] <= '0;
			for (int i = 0; i < GlyphRows; i++) begin
				win_s1[i+1] <= glyph_rows[GlyphCols*(GlyphRows-1-i) +: GlyphCols];
			end
		end else if (load_out && row_done) begin
			for (int i = 0; i < WinRows - 1; i++) begin
				win_s1[i] <= win_s1[i+1];
			end
			win_s1[WinRows-1] <= '0;
		end
	end

	gcr_scanline u_scanline (
		.prev_row (win_s1[0]),
		.cur_row  (win_s1[1]),
		.next_row (win_s1[2]),
		.sub      (sub_s1),
		.round_en (round_s1),
		.pixels   (line_pixels)
	);

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixels_q <= line_pixels;
			index_q  <= line_s1;
			last_q   <= last_line;
		end
	end

	assign out_valid       = out_valid_q;
	assign scanline_pixels = pixels_q;
	assign scanline_index  = index_q;
	assign last_scanline   = last_q;

endmodule
